@@ sv/assert_macros.svh @@
// Assertion macros shared by the frame engine RTL.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset
`define LSFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included
`define LSFE_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ sv/lsfe_pkg.sv @@
// Shared types, codes and helpers of the LIN slave frame engine.
// No dependencies; used by the interfaces and all engine modules.
`default_nettype none

package lsfe_pkg;

    // Field widths
    localparam int DATA_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int NUM_REGS   = 6;

    // Defaults for the top-level parameters
    localparam int MAX_DATA_DEF      = 8;
    localparam int TABLE_ENTRIES_DEF = 6;

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Bus constants
    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [5:0] ID_MASK   = 6'h3F;

    // Request types
    localparam logic [1:0] REQ_BYTE     = 2'd0;
    localparam logic [1:0] REQ_BREAK    = 2'd1;
    localparam logic [1:0] REQ_RESP     = 2'd2;
    localparam logic [1:0] REQ_LINE_ERR = 2'd3;

    // Event codes
    localparam logic [CODE_W-1:0] EV_FRAME     = 3'd0;
    localparam logic [CODE_W-1:0] EV_RESP_BYTE = 3'd1;
    localparam logic [CODE_W-1:0] EV_CSUM_ERR  = 3'd2;
    localparam logic [CODE_W-1:0] EV_UNKNOWN   = 3'd3;
    localparam logic [CODE_W-1:0] EV_SYNC_FAIL = 3'd4;

    // Frame table reset contents: id [5:0], master len [9:6], slave len [13:10]
    localparam logic [CFG_DATA_W-1:0] FRAME_RESET [NUM_REGS] = '{
        14'd4240, 14'd6560, 14'd176, 14'd8242, 14'd8243, 14'd127
    };

    // Front-to-back command: one report, or one response run
    typedef struct packed {
        logic              is_run;
        logic [CODE_W-1:0] code;
        logic [7:0]        pid;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              want;
    } t_cmd;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // 8-bit add with end-around carry (LIN checksum step)
    function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/lsfe_in_if.sv @@
// Input event channel of the frame engine: valid/ready plus event payload.
// Depends on lsfe_pkg for field widths.
`default_nettype none

interface lsfe_in_if
    import lsfe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [7:0]        rx_byte;
    logic              framing_error;
    logic [DATA_W-1:0] resp_data;
    logic [LEN_W-1:0]  resp_len;

    modport source (output valid, req_type, rx_byte, framing_error, resp_data, resp_len,
                    input ready);
    modport sink   (input valid, req_type, rx_byte, framing_error, resp_data, resp_len,
                    output ready);
endinterface

`default_nettype wire

@@ sv/lsfe_out_if.sv @@
// Result channel of the frame engine: valid/ready plus result payload.
// Depends on lsfe_pkg for field widths.
`default_nettype none

interface lsfe_out_if
    import lsfe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] event_code;
    logic [7:0]        frame_pid;
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0]  data_len;
    logic              response_wanted;
    logic [7:0]        tx_byte;
    logic              last;

    modport source (output valid, event_code, frame_pid, frame_data, data_len,
                    response_wanted, tx_byte, last, input ready);
    modport sink   (input valid, event_code, frame_pid, frame_data, data_len,
                    response_wanted, tx_byte, last, output ready);
endinterface

`default_nettype wire

@@ sv/lsfe_front.sv @@
// Front end: frame table, frame phase tracking, master data and checksum check.
// Depends on lsfe_pkg and lsfe_in_if; pushes commands into the queue.
`default_nettype none

module lsfe_front
    import lsfe_pkg::*;
#(
    parameter int MAX_DATA      = MAX_DATA_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lsfe_in_if.sink                    i_in,
    input  wire t_q_stat               i_q_stat,
    output logic                       o_push,
    output t_cmd                       o_cmd
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SYNC   = 3'd1;
    localparam logic [2:0] PH_PID    = 3'd2;
    localparam logic [2:0] PH_MASTER = 3'd3;
    localparam logic [2:0] PH_RESP   = 3'd4;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DATA);
    localparam int STORE_W = 8 * MAX_DATA;

    logic [CFG_DATA_W-1:0] r_tab [TABLE_ENTRIES];
    logic [2:0]            r_phase, n_phase;
    logic                  r_saw, n_saw;
    logic [7:0]            r_pid, n_pid;
    logic [LEN_W-1:0]      r_mcnt, n_mcnt;
    logic [LEN_W-1:0]      r_scnt, n_scnt;
    logic [LEN_W-1:0]      r_idx, n_idx;
    logic [7:0]            r_sum, n_sum;
    logic [STORE_W-1:0]    r_data, n_data;

    logic                  w_accept;
    logic [7:0]            w_b;
    logic                  w_hit;
    logic [CFG_DATA_W-1:0] w_entry;
    logic [LEN_W-1:0]      w_mlen, w_slen, w_rlen;
    logic                  w_begin;
    logic                  w_match;

    assign i_in.ready = !i_q_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.rx_byte;

    // Table lookup, lowest entry wins
    always_comb begin
        w_hit   = 1'b0;
        w_entry = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if ((r_tab[k][5:0] & ID_MASK) == (w_b[5:0] & ID_MASK)) begin
                w_hit   = 1'b1;
                w_entry = r_tab[k];
            end
        end
    end

    assign w_mlen  = (w_entry[9:6] > MAX_LEN) ? MAX_LEN : w_entry[9:6];
    assign w_slen  = (w_entry[13:10] > MAX_LEN) ? MAX_LEN : w_entry[13:10];
    assign w_rlen  = (i_in.resp_len < r_scnt) ? i_in.resp_len : r_scnt;
    assign w_match = (w_b == ~r_sum);

    // Event handling
    always_comb begin
        n_phase = r_phase;
        n_saw   = r_saw;
        n_pid   = r_pid;
        n_mcnt  = r_mcnt;
        n_scnt  = r_scnt;
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_data  = r_data;
        w_begin = 1'b0;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (w_accept) begin
            case (i_in.req_type)
                REQ_BREAK: begin
                    n_phase = PH_SYNC;
                    n_saw   = 1'b0;
                end
                REQ_LINE_ERR: begin
                    n_phase = (i_in.framing_error && r_phase == PH_IDLE) ? PH_SYNC : PH_IDLE;
                    n_saw   = 1'b0;
                end
                REQ_RESP: begin
                    if (r_phase == PH_RESP) begin
                        n_phase = PH_IDLE;
                        n_saw   = 1'b0;
                        if (w_rlen != '0) begin
                            o_push      = 1'b1;
                            o_cmd.is_run = 1'b1;
                            o_cmd.code  = EV_RESP_BYTE;
                            o_cmd.pid   = r_pid;
                            o_cmd.data  = i_in.resp_data;
                            o_cmd.len   = w_rlen;
                        end
                    end
                end
                default: begin
                    // received byte
                    case (r_phase)
                        PH_IDLE: begin
                            if (r_saw && w_hit) begin
                                w_begin = 1'b1;
                            end else begin
                                n_saw = (w_b == SYNC_BYTE);
                            end
                        end
                        PH_SYNC: begin
                            if (w_b == SYNC_BYTE) begin
                                n_phase = PH_PID;
                            end else begin
                                n_phase    = PH_IDLE;
                                n_saw      = 1'b0;
                                o_push     = 1'b1;
                                o_cmd.code = EV_SYNC_FAIL;
                            end
                        end
                        PH_PID: begin
                            if (w_hit) begin
                                w_begin = 1'b1;
                            end else begin
                                n_phase    = PH_IDLE;
                                n_saw      = 1'b0;
                                o_push     = 1'b1;
                                o_cmd.code = EV_UNKNOWN;
                                o_cmd.pid  = w_b;
                            end
                        end
                        PH_MASTER: begin
                            if (r_idx != r_mcnt) begin
                                // data byte: store and fold into the checksum
                                for (int k = 0; k < MAX_DATA; k++) begin
                                    if (r_idx == LEN_W'(k)) begin
                                        n_data[8*k +: 8] = w_b;
                                    end
                                end
                                n_sum = add_carry(r_sum, w_b);
                                n_idx = r_idx + 1'b1;
                            end else begin
                                // checksum byte closes the master part
                                o_push     = 1'b1;
                                o_cmd.code = w_match ? EV_FRAME : EV_CSUM_ERR;
                                o_cmd.pid  = r_pid;
                                o_cmd.data = DATA_W'(r_data);
                                o_cmd.len  = r_mcnt;
                                o_cmd.want = w_match && (r_scnt != '0);
                                n_phase    = (w_match && r_scnt != '0) ? PH_RESP : PH_IDLE;
                                n_saw      = 1'b0;
                            end
                        end
                        default: begin
                            // waiting for a response, or an unused code: drop frame
                            n_phase = PH_IDLE;
                            n_saw   = 1'b0;
                        end
                    endcase
                end
            endcase
        end

        // Frame start on a known PID
        if (w_begin) begin
            n_pid  = w_b;
            n_mcnt = w_mlen;
            n_scnt = w_slen;
            n_idx  = '0;
            n_saw  = 1'b0;
            n_sum  = w_b;
            n_data = '0;
            if (w_mlen != '0) begin
                n_phase = PH_MASTER;
            end else if (w_slen != '0) begin
                n_phase    = PH_RESP;
                o_push     = 1'b1;
                o_cmd.code = EV_FRAME;
                o_cmd.pid  = w_b;
                o_cmd.want = 1'b1;
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Frame table registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (!i_rst_n) begin
                r_tab[k] <= FRAME_RESET[k];
            end else if (i_cfg_we && i_cfg_idx == CFG_IDX_W'(k)) begin
                r_tab[k] <= i_cfg_data;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_saw   <= 1'b0;
            r_pid   <= '0;
            r_mcnt  <= '0;
            r_scnt  <= '0;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_saw   <= n_saw;
            r_pid   <= n_pid;
            r_mcnt  <= n_mcnt;
            r_scnt  <= n_scnt;
            r_idx   <= n_idx;
        end
    end

    // Data and running checksum
    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_data <= n_data;
    end

endmodule

`default_nettype wire

@@ sv/lsfe_cmd_fifo.sv @@
// Short command queue between the front and back of the frame engine.
// Depends on lsfe_pkg for the command type and depth.
`default_nettype none

module lsfe_cmd_fifo
    import lsfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;

    function automatic logic [Q_PTR_W-1:0] bump(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head           = r_mem[r_rptr];
    assign o_stat.full      = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.not_empty = (r_cnt != '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/lsfe_back.sv @@
// Back end: turns queued commands into result beats, one per cycle while the output is ready.
// Depends on lsfe_pkg and lsfe_out_if; response runs end with a checksum beat.
`default_nettype none

module lsfe_back
    import lsfe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    lsfe_out_if.source   o_res
);

    logic              r_ov;
    logic [LEN_W-1:0]  r_idx;
    logic [7:0]        r_sum;
    logic [CODE_W-1:0] r_code;
    logic [7:0]        r_pid;
    logic [DATA_W-1:0] r_data;
    logic [LEN_W-1:0]  r_len;
    logic              r_want;
    logic [7:0]        r_tx;
    logic              r_last;

    logic       w_load;
    logic       w_is_last;
    logic [7:0] w_byte;
    logic [7:0] w_sum_cur;

    assign w_load    = i_q_stat.not_empty && (!r_ov || o_res.ready);
    assign w_is_last = i_head.is_run && (r_idx == i_head.len);
    assign w_byte    = i_head.data[{r_idx[2:0], 3'b000} +: 8];
    assign w_sum_cur = (r_idx == '0) ? i_head.pid : r_sum;
    assign o_pop     = w_load && (!i_head.is_run || w_is_last);

    assign o_res.valid           = r_ov;
    assign o_res.event_code      = r_code;
    assign o_res.frame_pid       = r_pid;
    assign o_res.frame_data      = r_data;
    assign o_res.data_len        = r_len;
    assign o_res.response_wanted = r_want;
    assign o_res.tx_byte         = r_tx;
    assign o_res.last            = r_last;

    // Output valid and run position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (w_load && i_head.is_run) begin
                r_idx <= w_is_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Result payload and running response checksum
    always_ff @(posedge i_clk) begin
        if (w_load && i_head.is_run && !w_is_last) begin
            r_sum <= add_carry(w_sum_cur, w_byte);
        end
        if (w_load) begin
            r_pid <= i_head.pid;
            if (i_head.is_run) begin
                r_code <= EV_RESP_BYTE;
                r_data <= '0;
                r_len  <= '0;
                r_want <= 1'b0;
                r_tx   <= w_is_last ? ~w_sum_cur : w_byte;
                r_last <= w_is_last;
            end else begin
                r_code <= i_head.code;
                r_data <= i_head.data;
                r_len  <= i_head.len;
                r_want <= i_head.want;
                r_tx   <= '0;
                r_last <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/lin_slave_frame_engine_unit.sv @@
// LIN slave frame engine with enhanced checksum. The front end takes one event
// per cycle (break, received byte, response, line error) whenever its two-entry
// command queue has room, and handles sync, PID lookup and master data in that
// cycle. The back end drains the queue into the result channel at one beat per
// cycle while that channel is ready, through an output register: a frame report,
// sync fail, unknown id or checksum error is one beat; a response of n bytes is
// n + 1 beats, the last one the checksum. A result is registered first in the
// command queue and then in the output register.
// Depends on lsfe_pkg, lsfe_in_if, lsfe_out_if, lsfe_front, lsfe_cmd_fifo,
// lsfe_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lin_slave_frame_engine_unit
    import lsfe_pkg::*;
#(
    parameter int MAX_DATA      = MAX_DATA_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lsfe_in_if.sink                    i_in,
    lsfe_out_if.source                 o_res
);

    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd;
    t_cmd    w_head;
    t_q_stat w_q_stat;

    lsfe_front #(
        .MAX_DATA      (MAX_DATA),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    lsfe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    lsfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

    // Queue integrity and result framing
    `LSFE_ASSERT(a_no_overflow, w_push |-> !w_q_stat.full, "command pushed into full queue")
    `LSFE_ASSERT(a_no_underflow, w_pop |-> w_q_stat.not_empty, "pop from empty queue")
    `LSFE_ASSERT(a_last_on_resp,
        (o_res.valid && o_res.last) |-> (o_res.event_code == EV_RESP_BYTE),
        "last flag on non-response beat")
    `LSFE_ASSERT_ALL(a_reset_empty,
        !i_rst_n |=> (!w_q_stat.not_empty && !o_res.valid),
        "queue or output not cleared by reset")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for lin_slave_frame_engine_unit: break/sync/PID handling,
// master data with enhanced checksum, response runs and line errors.
// Depends on lsfe_pkg, lsfe_in_if, lsfe_out_if and the engine RTL.
`default_nettype none

import lsfe_pkg::*;

// One event beat on the input channel
typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        rx_byte;
    logic              framing_error;
    logic [DATA_W-1:0] resp_data;
    logic [LEN_W-1:0]  resp_len;
} t_lin_event;

// One result beat on the output channel
typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [7:0]        pid;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              want;
    logic [7:0]        tx;
    logic              last;
} t_frame_result;

typedef enum logic [2:0] {
    LINK_IDLE, LINK_SYNC, LINK_PID, LINK_MASTER, LINK_RESP
} t_link_state;

// Frame-engine predictor plus the queue of results still to arrive
class lin_frame_scoreboard;
    logic [CFG_DATA_W-1:0] frame_tbl [NUM_REGS];
    t_link_state           st;
    bit                    saw_sync;
    logic [7:0]            cur_pid;
    int unsigned           m_cnt;
    int unsigned           s_cnt;
    int unsigned           b_idx;
    logic [7:0]            rx_store [MAX_DATA_DEF + 1];
    t_frame_result         pending_results [$];
    int                    n_errors;
    int                    n_checked;
    int                    n_frames;
    int                    n_resp_beats;
    int                    n_err_reports;

    function new();
        foreach (frame_tbl[i]) frame_tbl[i] = FRAME_RESET[i];
        foreach (rx_store[i]) rx_store[i] = 8'h00;
        st = LINK_IDLE;
        saw_sync = 0;
        cur_pid = 8'h00;
        m_cnt = 0;
        s_cnt = 0;
        b_idx = 0;
    endfunction

    function void write_entry(int idx, logic [CFG_DATA_W-1:0] v);
        frame_tbl[idx] = v;
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    function int unsigned clip_len(logic [3:0] v);
        return (v > MAX_DATA_DEF) ? MAX_DATA_DEF : int'(v);
    endfunction

    // First table entry whose id matches, lowest index first
    function int find_entry(logic [5:0] id);
        for (int i = 0; i < TABLE_ENTRIES_DEF && i < NUM_REGS; i++) begin
            if ((frame_tbl[i][5:0] & ID_MASK) == id) return i;
        end
        return -1;
    endfunction

    // Enhanced checksum: PID plus data, end-around carry, inverted
    function logic [7:0] lin_checksum(logic [7:0] pid, logic [7:0] bytes [MAX_DATA_DEF + 1],
                                      int unsigned n);
        int unsigned acc;
        acc = pid;
        for (int unsigned i = 0; i < n; i++) begin
            acc += bytes[i];
            if (acc > 255) acc = (acc & 255) + 1;
        end
        return ~acc[7:0];
    endfunction

    function void post(logic [CODE_W-1:0] code, logic [7:0] pid, logic [DATA_W-1:0] data,
                       logic [LEN_W-1:0] len, logic want, logic [7:0] tx, logic last);
        t_frame_result r;
        r.code = code;
        r.pid  = pid;
        r.data = data;
        r.len  = len;
        r.want = want;
        r.tx   = tx;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function void go_idle();
        saw_sync = 0;
        st = LINK_IDLE;
    endfunction

    function void start_frame(int e, logic [7:0] pid);
        cur_pid = pid;
        m_cnt = clip_len(frame_tbl[e][9:6]);
        s_cnt = clip_len(frame_tbl[e][13:10]);
        b_idx = 0;
        saw_sync = 0;
        if (m_cnt > 0) begin
            st = LINK_MASTER;
        end else if (s_cnt > 0) begin
            // slave-only frame is announced at once
            post(EV_FRAME, pid, '0, '0, 1'b1, 8'h00, 1'b0);
            st = LINK_RESP;
        end else begin
            go_idle();
        end
    endfunction

    function void take_byte(logic [7:0] b);
        int e;
        logic [DATA_W-1:0] packed_data;
        case (st)
            LINK_IDLE: begin
                // sync followed by a known PID starts a frame without a break
                if (saw_sync) begin
                    saw_sync = 0;
                    e = find_entry(b[5:0]);
                    if (e >= 0) begin
                        start_frame(e, b);
                        return;
                    end
                end
                saw_sync = (b == SYNC_BYTE);
            end
            LINK_SYNC: begin
                if (b == SYNC_BYTE) begin
                    st = LINK_PID;
                end else begin
                    go_idle();
                    post(EV_SYNC_FAIL, 8'h00, '0, '0, 1'b0, 8'h00, 1'b0);
                end
            end
            LINK_PID: begin
                e = find_entry(b[5:0]);
                if (e < 0) begin
                    go_idle();
                    post(EV_UNKNOWN, b, '0, '0, 1'b0, 8'h00, 1'b0);
                end else begin
                    start_frame(e, b);
                end
            end
            LINK_MASTER: begin
                if (b_idx <= MAX_DATA_DEF) rx_store[b_idx] = b;
                b_idx++;
                if (b_idx < m_cnt + 1) return;
                packed_data = '0;
                for (int unsigned i = 0; i < m_cnt && i < 8; i++)
                    packed_data[8*i +: 8] = rx_store[i];
                if (rx_store[m_cnt] != lin_checksum(cur_pid, rx_store, m_cnt)) begin
                    post(EV_CSUM_ERR, cur_pid, packed_data, LEN_W'(m_cnt), 1'b0, 8'h00, 1'b0);
                    go_idle();
                end else begin
                    post(EV_FRAME, cur_pid, packed_data, LEN_W'(m_cnt), s_cnt > 0, 8'h00,
                         1'b0);
                    if (s_cnt > 0) begin
                        saw_sync = 0;
                        st = LINK_RESP;
                    end else begin
                        go_idle();
                    end
                end
            end
            default: go_idle();  // byte while awaiting a response drops it
        endcase
    endfunction

    // Predict the results of one accepted event beat
    function void note_event(t_lin_event ev);
        logic [7:0]  tx [MAX_DATA_DEF + 1];
        int unsigned n;
        case (ev.req_type)
            REQ_BREAK: begin
                saw_sync = 0;
                st = LINK_SYNC;
            end
            REQ_LINE_ERR: begin
                if (ev.framing_error && st == LINK_IDLE) begin
                    saw_sync = 0;
                    st = LINK_SYNC;
                end else begin
                    go_idle();
                end
            end
            REQ_RESP: begin
                if (st != LINK_RESP) return;
                n = (ev.resp_len < s_cnt) ? int'(ev.resp_len) : s_cnt;
                go_idle();
                if (n == 0) return;
                foreach (tx[i]) tx[i] = 8'h00;
                for (int unsigned i = 0; i < n; i++) begin
                    tx[i] = ev.resp_data[8*i +: 8];
                    post(EV_RESP_BYTE, cur_pid, '0, '0, 1'b0, tx[i], 1'b0);
                end
                post(EV_RESP_BYTE, cur_pid, '0, '0, 1'b0, lin_checksum(cur_pid, tx, n), 1'b1);
            end
            default: take_byte(ev.rx_byte);
        endcase
    endfunction

    function string fmt(t_frame_result r);
        return $sformatf("code=%0d pid=%02h data=%016h len=%0d want=%0d tx=%02h last=%0d",
                         r.code, r.pid, r.data, r.len, r.want, r.tx, r.last);
    endfunction

    function void report(string what, string detail);
        n_errors++;
        if (n_errors <= 10) $display("error %0d: %s\n  %s", n_errors, what, detail);
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_result(t_frame_result got);
        t_frame_result want;
        bit bad;
        n_checked++;
        case (got.code)
            EV_FRAME:     n_frames++;
            EV_RESP_BYTE: n_resp_beats++;
            default:      n_err_reports++;
        endcase
        if (pending_results.size() == 0) begin
            report("result beat with nothing predicted", $sformatf("actual   %s", fmt(got)));
            return;
        end
        want = pending_results.pop_front();
        bad = 0;
        if (got.code !== want.code) bad = 1;
        if (got.pid  !== want.pid)  bad = 1;
        if (got.data !== want.data) bad = 1;
        if (got.len  !== want.len)  bad = 1;
        if (got.want !== want.want) bad = 1;
        if (got.tx   !== want.tx)   bad = 1;
        if (got.last !== want.last) bad = 1;
        if (bad)
            report("result mismatch",
                   $sformatf("expected %s\n  actual   %s", fmt(want), fmt(got)));
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          DIRECTED_END  = 25;
    localparam int          PHASE_A_END   = 170;
    localparam int          PHASE_B_END   = 315;
    localparam int          ITEMS_TOTAL   = 460;

    bit                    i_clk = 0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           cycle_count = 0;
    int                    n_sent = 0;
    int                    n_cfg_writes = 0;
    bit                    calm_in = 0;
    bit                    calm_out = 0;
    lin_frame_scoreboard   sb;

    lsfe_in_if  in_ch ();
    lsfe_out_if res_ch ();

    lin_slave_frame_engine_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    // Idle cycles before a beat; calm stretches have none
    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // Event with random filler in the fields the event type does not use
    function automatic t_lin_event mk_event(logic [1:0] kind, logic [7:0] b);
        t_lin_event ev;
        ev.req_type      = kind;
        ev.rx_byte       = b;
        ev.framing_error = 1'($urandom);
        ev.resp_data     = {$urandom, $urandom};
        ev.resp_len      = LEN_W'($urandom_range(0, 8));
        return ev;
    endfunction

    // Present one event beat and hold it until the engine takes it
    task automatic send_event(t_lin_event ev);
        int gap;
        gap = draw_gap(calm_in);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= ev.req_type;
        in_ch.rx_byte       <= ev.rx_byte;
        in_ch.framing_error <= ev.framing_error;
        in_ch.resp_data     <= ev.resp_data;
        in_ch.resp_len      <= ev.resp_len;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_event(ev);
        n_sent++;
        if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_event(mk_event(REQ_BYTE, b));
    endtask

    task automatic send_break();
        send_event(mk_event(REQ_BREAK, 8'($urandom)));
    endtask

    task automatic send_line_err(logic fe);
        t_lin_event ev;
        ev = mk_event(REQ_LINE_ERR, 8'($urandom));
        ev.framing_error = fe;
        send_event(ev);
    endtask

    task automatic send_resp(logic [DATA_W-1:0] data, int len);
        t_lin_event ev;
        ev = mk_event(REQ_RESP, 8'($urandom));
        ev.resp_data = data;
        ev.resp_len  = LEN_W'(len);
        send_event(ev);
    endtask

    // Master bytes followed by their checksum, optionally corrupted
    task automatic send_data(logic [7:0] pid, logic [7:0] d [MAX_DATA_DEF + 1],
                             int unsigned m, bit good);
        logic [7:0] cs;
        for (int unsigned i = 0; i < m; i++) send_byte(d[i]);
        cs = sb.lin_checksum(pid, d, m);
        if (!good) cs = cs ^ 8'($urandom_range(1, 255));
        send_byte(cs);
    endtask

    // Header, master data and response of one frame, shaped by the current table
    task automatic send_frame(bit via_break, logic [7:0] pid, bit good);
        logic [7:0]  d [MAX_DATA_DEF + 1];
        int          e;
        int unsigned m;
        int unsigned s;
        if (via_break) send_break();
        send_byte(SYNC_BYTE);
        send_byte(pid);
        e = sb.find_entry(pid[5:0]);
        if (e < 0) return;
        m = sb.clip_len(sb.frame_tbl[e][9:6]);
        s = sb.clip_len(sb.frame_tbl[e][13:10]);
        // occasional abort right after the header
        if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) == 0) send_break();
            else send_line_err(1'($urandom));
            return;
        end
        foreach (d[i]) d[i] = 8'($urandom);
        if (m > 0) send_data(pid, d, m, good);
        if (s == 0 || (m > 0 && !good)) return;
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
        else send_resp({$urandom, $urandom}, $urandom_range(0, 8));
    endtask

    // One random sequence: mostly well-formed frames, some broken ones and noise
    task automatic send_random_seq();
        int         r;
        logic [7:0] pid;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        pid = {2'($urandom), sb.frame_tbl[$urandom_range(0, NUM_REGS - 1)][5:0]};
        if (r < 60) begin
            send_frame(1'b1, pid, $urandom_range(0, 99) < 85);
        end else if (r < 72) begin
            send_frame(1'b0, pid, $urandom_range(0, 99) < 85);
        end else if (r < 80) begin
            send_frame(1'b1, 8'($urandom), 1'b1);
        end else if (r < 85) begin
            b = 8'($urandom);
            if (b == SYNC_BYTE) b = b ^ 8'h01;
            send_break();
            send_byte(b);
        end else begin
            send_event(mk_event(2'($urandom), 8'($urandom)));
        end
    endtask

    // Drop valid, wait for every predicted beat, then let the engine go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_table(logic [CFG_DATA_W-1:0] vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_entry(i, vals[i]);
            n_cfg_writes++;
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_entry(bit wide);
        logic [3:0] m;
        logic [3:0] s;
        m = wide ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
        s = wide ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
        return {s, m, 6'($urandom_range(0, 63))};
    endfunction

    // Result side: random stalls, check every accepted beat
    initial begin
        t_frame_result got;
        int            gap;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = draw_gap(calm_out);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.code = res_ch.event_code;
            got.pid  = res_ch.frame_pid;
            got.data = res_ch.frame_data;
            got.len  = res_ch.data_len;
            got.want = res_ch.response_wanted;
            got.tx   = res_ch.tx_byte;
            got.last = res_ch.last;
            sb.check_result(got);
            if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
        end
    end

    // Stimulus
    initial begin
        logic [7:0]            d [MAX_DATA_DEF + 1];
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        sb = new();
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.req_type      <= REQ_BYTE;
        in_ch.rx_byte       <= 8'h00;
        in_ch.framing_error <= 1'b0;
        in_ch.resp_data     <= '0;
        in_ch.resp_len      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset table: sync fail, unknown id
        send_break();
        send_byte(8'h00);
        send_break();
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        // one master byte, good checksum, no response
        foreach (d[i]) d[i] = 8'h00;
        d[0] = 8'hFF;
        send_break();
        send_byte(SYNC_BYTE);
        send_byte(8'hFF);
        send_data(8'hFF, d, 1, 1'b1);
        // slave-only frame with a full eight-byte response
        send_break();
        send_byte(SYNC_BYTE);
        send_byte(8'h32);
        send_resp({DATA_W{1'b1}}, 8);
        // frame started from idle without a break, bad checksum
        d[0] = 8'hAA;
        d[1] = 8'h55;
        send_byte(SYNC_BYTE);
        send_byte(8'h10);
        send_data(8'h10, d, 2, 1'b0);
        // framing error as break, response abandoned by a byte, stray response
        send_line_err(1'b1);
        send_byte(SYNC_BYTE);
        send_byte(8'hB3);
        send_byte(8'h12);
        send_resp({$urandom, $urandom}, 3);
        send_line_err(1'b0);
        while (n_sent < DIRECTED_END) send_random_seq();

        // Random table within the documented range
        settle();
        foreach (vals[i]) vals[i] = rand_entry(1'b0);
        load_table(vals);
        while (n_sent < PHASE_A_END) send_random_seq();

        // Extremes: empty frame, saturated lengths, duplicate ids, top of range
        settle();
        vals[0] = 14'd0;
        vals[1] = 14'h3FFF;
        vals[2] = {4'd0, 4'd8, 6'd7};
        vals[3] = {4'd8, 4'd0, 6'd9};
        vals[4] = {4'd1, 4'd1, 6'd63};
        vals[5] = 14'd8767;
        load_table(vals);
        while (n_sent < PHASE_B_END) send_random_seq();

        // Random table over the full register width
        settle();
        foreach (vals[i]) vals[i] = rand_entry(1'b1);
        load_table(vals);
        while (n_sent < ITEMS_TOTAL) send_random_seq();

        settle();
        $display("summary: %0d events, %0d table writes, %0d result beats checked",
                 n_sent, n_cfg_writes, sb.n_checked);
        $display("summary: %0d frame reports, %0d response beats, %0d error reports",
                 sb.n_frames, sb.n_resp_beats, sb.n_err_reports);
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
